FILE: rtl/nec_pkg.sv
package nec_pkg;

  localparam int REG_W         = 20;
  localparam int ENV_W         = 20;
  localparam int LEN_W         = 7;
  localparam int MAX_ENV_DEF   = 64;
  localparam int SIZE_BITS_DEF = 20;
  localparam int CFG_IDX_W     = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_CARD_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_CARD_HEIGHT = 1'b1;

  typedef struct packed {
    logic [ENV_W-1:0] env_width;
    logic [ENV_W-1:0] env_height;
    logic             last_item;
  } nec_env_t;

  typedef struct packed {
    logic [LEN_W-1:0] chain_length;
    logic [LEN_W-1:0] envelope_number;
    logic             entry_valid;
    logic             overflow;
    logic             last_result;
  } nec_res_t;

  typedef struct packed {
    logic [REG_W-1:0] width;
    logic [REG_W-1:0] height;
  } nec_card_t;

endpackage

FILE: rtl/nec_chan_if.sv
interface nec_chan_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/nec_core.sv
module nec_core #(
  parameter int MAX_ENVELOPES = nec_pkg::MAX_ENV_DEF,
  parameter int SIZE_BITS     = nec_pkg::SIZE_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  nec_pkg::nec_env_t  in_data,
  input  nec_pkg::nec_card_t card,
  output logic               res_valid,
  input  logic               res_ready,
  output nec_pkg::nec_res_t  res_data
);
  import nec_pkg::*;

  localparam int AW = $clog2(MAX_ENVELOPES);
  localparam int CW = $clog2(MAX_ENVELOPES + 1);
  localparam int SB = SIZE_BITS;
  localparam int KW = (SIZE_BITS > REG_W) ? SIZE_BITS : REG_W;
  localparam logic [CW-1:0] MAXC = CW'(MAX_ENVELOPES);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_RK_KEY   = 4'd1;
  localparam logic [3:0] S_RK_KEYW  = 4'd2;
  localparam logic [3:0] S_RK_SCAN  = 4'd3;
  localparam logic [3:0] S_RK_WR    = 4'd4;
  localparam logic [3:0] S_DP_I     = 4'd5;
  localparam logic [3:0] S_DP_IW    = 4'd6;
  localparam logic [3:0] S_DP_SCAN  = 4'd7;
  localparam logic [3:0] S_MX_SCAN  = 4'd8;
  localparam logic [3:0] S_BT_RD    = 4'd9;
  localparam logic [3:0] S_BT_WR    = 4'd10;
  localparam logic [3:0] S_EM_RD    = 4'd11;
  localparam logic [3:0] S_EM_OUT   = 4'd12;
  localparam logic [3:0] S_EM_EMPTY = 4'd13;

  logic [3:0]    state;
  logic [CW-1:0] n, ci, cj, best, pos, len, k;
  logic [AW-1:0] rank, pidx;
  logic          pv, ovf;
  logic [SB-1:0] kw, kh, iw, ih;
  logic [CW-1:0] ib;

  // Arrival-order store, sorted store, chain table store, chain buffer.
  logic [SB-1:0] l_w [MAX_ENVELOPES];
  logic [SB-1:0] l_h [MAX_ENVELOPES];
  logic [SB-1:0] s_w [MAX_ENVELOPES];
  logic [SB-1:0] s_h [MAX_ENVELOPES];
  logic [CW-1:0] s_a [MAX_ENVELOPES];
  logic [CW-1:0] d_b [MAX_ENVELOPES];
  logic [CW-1:0] d_p [MAX_ENVELOPES];
  logic [CW-1:0] c_a [MAX_ENVELOPES];

  logic [SB-1:0] l_wq, l_hq, s_wq, s_hq;
  logic [CW-1:0] s_aq, d_bq, d_pq, c_aq;

  logic          l_re, s_re, c_re, scan_issue, accept;
  logic [AW-1:0] l_ra, s_ra, c_ra;
  logic [CW-1:0] pos_m1, c_idx, ci_inc, k_inc, len_inc;
  logic [CW:0]   ib_inc;
  logic [KW-1:0] a_w, a_h, b_w, b_h;
  logic          w_gt, w_eq, h_gt, h_eq, earlier, fit, upd, scan_done;

  assign accept     = in_valid && (state == S_IDLE);
  assign in_ready   = (state == S_IDLE);
  assign scan_issue = (cj < n);
  assign scan_done  = !pv && (cj == n);
  assign pos_m1     = pos - 1'b1;
  assign c_idx      = len - k - 1'b1;
  assign ci_inc     = ci + 1'b1;
  assign k_inc      = k + 1'b1;
  assign len_inc    = len + 1'b1;
  assign ib_inc     = {1'b0, ib} + 1'b1;

  // Shared compare unit: operands chosen by the phase.
  always_comb begin
    if (state == S_RK_SCAN) begin
      a_w = KW'(kw);   a_h = KW'(kh);
      b_w = KW'(l_wq); b_h = KW'(l_hq);
    end else if (state == S_DP_SCAN) begin
      a_w = KW'(s_wq); a_h = KW'(s_hq);
      b_w = KW'(iw);   b_h = KW'(ih);
    end else begin
      a_w = KW'(kw);         a_h = KW'(kh);
      b_w = KW'(card.width); b_h = KW'(card.height);
    end
  end

  assign w_gt    = a_w > b_w;
  assign w_eq    = a_w == b_w;
  assign h_gt    = a_h > b_h;
  assign h_eq    = a_h == b_h;
  assign fit     = w_gt && h_gt;
  assign earlier = w_gt || (w_eq && h_gt) || (w_eq && h_eq && (pidx < ci[AW-1:0]));
  assign upd     = pv && fit && ({1'b0, d_bq} < ib_inc);

  always_comb begin
    l_re = (state == S_RK_KEY) || ((state == S_RK_SCAN) && scan_issue);
    l_ra = (state == S_RK_KEY) ? ci[AW-1:0] : cj[AW-1:0];
    s_re = (state == S_DP_I) || (state == S_BT_RD) ||
           (((state == S_DP_SCAN) || (state == S_MX_SCAN)) && scan_issue);
    if (state == S_DP_I) begin
      s_ra = ci[AW-1:0];
    end else if (state == S_BT_RD) begin
      s_ra = pos_m1[AW-1:0];
    end else begin
      s_ra = cj[AW-1:0];
    end
    c_re = (state == S_EM_RD);
    c_ra = c_idx[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (accept && (n < MAXC)) begin
      l_w[n[AW-1:0]] <= SB'(in_data.env_width);
      l_h[n[AW-1:0]] <= SB'(in_data.env_height);
    end
    if (l_re) begin
      l_wq <= l_w[l_ra];
      l_hq <= l_h[l_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RK_WR) begin
      s_w[rank] <= kw;
      s_h[rank] <= kh;
      s_a[rank] <= ci_inc;
    end
    if (s_re) begin
      s_wq <= s_w[s_ra];
      s_hq <= s_h[s_ra];
      s_aq <= s_a[s_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_RK_WR) begin
      d_b[rank] <= fit ? CW'(1) : '0;
      d_p[rank] <= '0;
    end else if ((state == S_DP_SCAN) && upd) begin
      d_b[pidx] <= ib_inc[CW-1:0];
      d_p[pidx] <= ci_inc;
    end
    if (s_re) begin
      d_bq <= d_b[s_ra];
      d_pq <= d_p[s_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_BT_WR) begin
      c_a[len[AW-1:0]] <= s_aq;
    end
    if (c_re) begin
      c_aq <= c_a[c_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      n     <= '0;
      ovf   <= 1'b0;
      pv    <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            if (n < MAXC) begin
              n <= n + 1'b1;
            end else begin
              ovf <= 1'b1;
            end
            if (in_data.last_item) begin
              ci    <= '0;
              state <= S_RK_KEY;
            end
          end
        end
        S_RK_KEY: state <= S_RK_KEYW;
        S_RK_KEYW: begin
          kw    <= l_wq;
          kh    <= l_hq;
          cj    <= '0;
          rank  <= '0;
          pv    <= 1'b0;
          state <= S_RK_SCAN;
        end
        S_RK_SCAN: begin
          pv   <= scan_issue;
          pidx <= cj[AW-1:0];
          if (scan_issue) begin
            cj <= cj + 1'b1;
          end
          if (pv && earlier) begin
            rank <= rank + 1'b1;
          end
          if (scan_done) begin
            state <= S_RK_WR;
          end
        end
        S_RK_WR: begin
          if (ci_inc == n) begin
            ci    <= '0;
            state <= S_DP_I;
          end else begin
            ci    <= ci_inc;
            state <= S_RK_KEY;
          end
        end
        S_DP_I: state <= S_DP_IW;
        S_DP_IW: begin
          iw <= s_wq;
          ih <= s_hq;
          ib <= d_bq;
          cj <= '0;
          pv <= 1'b0;
          if (d_bq != '0) begin
            state <= S_DP_SCAN;
          end else if (ci_inc == n) begin
            best  <= '0;
            pos   <= '0;
            state <= S_MX_SCAN;
          end else begin
            ci    <= ci_inc;
            state <= S_DP_I;
          end
        end
        S_DP_SCAN: begin
          pv   <= scan_issue;
          pidx <= cj[AW-1:0];
          if (scan_issue) begin
            cj <= cj + 1'b1;
          end
          if (scan_done) begin
            if (ci_inc == n) begin
              cj    <= '0;
              best  <= '0;
              pos   <= '0;
              state <= S_MX_SCAN;
            end else begin
              ci    <= ci_inc;
              state <= S_DP_I;
            end
          end
        end
        S_MX_SCAN: begin
          pv   <= scan_issue;
          pidx <= cj[AW-1:0];
          if (scan_issue) begin
            cj <= cj + 1'b1;
          end
          if (pv && (d_bq > best)) begin
            best <= d_bq;
            pos  <= CW'(pidx) + 1'b1;
          end
          if (scan_done) begin
            len   <= '0;
            state <= (best == '0) ? S_EM_EMPTY : S_BT_RD;
          end
        end
        S_BT_RD: state <= S_BT_WR;
        S_BT_WR: begin
          len <= len_inc;
          pos <= d_pq;
          if ((d_pq == '0) || (len_inc == MAXC)) begin
            k     <= '0;
            state <= S_EM_RD;
          end else begin
            state <= S_BT_RD;
          end
        end
        S_EM_RD: state <= S_EM_OUT;
        S_EM_OUT: begin
          if (res_ready) begin
            if (k_inc == len) begin
              n     <= '0;
              ovf   <= 1'b0;
              state <= S_IDLE;
            end else begin
              k     <= k_inc;
              state <= S_EM_RD;
            end
          end
        end
        S_EM_EMPTY: begin
          if (res_ready) begin
            n     <= '0;
            ovf   <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    res_valid = (state == S_EM_OUT) || (state == S_EM_EMPTY);
    res_data.overflow = ovf;
    if (state == S_EM_OUT) begin
      res_data.chain_length    = LEN_W'(best);
      res_data.envelope_number = LEN_W'(c_aq);
      res_data.entry_valid     = 1'b1;
      res_data.last_result     = (k_inc == len);
    end else begin
      res_data.chain_length    = '0;
      res_data.envelope_number = '0;
      res_data.entry_valid     = 1'b0;
      res_data.last_result     = 1'b1;
    end
  end

endmodule

FILE: rtl/nested_envelope_chain.sv
// Channel | Dir | Payload                                                  | Beat when
// env     | in  | env_width, env_height, last_item                         | valid && ready
// res     | out | chain_length, envelope_number, entry_valid, overflow,    | valid && ready
//         |     | last_result                                              |
// cfg     | in  | cfg_index (0 card width, 1 card height), cfg_data        | cfg_we
//
// Loading accepts one envelope beat per cycle. The beat marked last starts a run
// of ranking, then the chain table pass, the best-length search, and the
// backtrack and readout of the chain members. Ranking and the chain table pass
// share one compare unit; all stores are memories with registered reads.
// Reset is synchronous and active high; the stores need no clearing pass.
// env.ready is low for the whole run; a stalled res beat holds in the output register.
module nested_envelope_chain #(
  parameter int MAX_ENVELOPES = nec_pkg::MAX_ENV_DEF,
  parameter int SIZE_BITS     = nec_pkg::SIZE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [nec_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nec_pkg::REG_W-1:0]    cfg_data,
  nec_chan_if.sink                     env,
  nec_chan_if.source                   res
);
  import nec_pkg::*;

  // Card size registers, for the user to write only while the block is idle; unchecked.
  nec_card_t card;

  // Core result handshake, and the output register that decouples the core
  // from a stalled sink.
  logic     core_valid;
  logic     core_ready;
  nec_res_t core_data;
  logic     out_valid;
  nec_res_t out_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      card.width  <= REG_W'(1);
      card.height <= REG_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CARD_WIDTH:  card.width  <= cfg_data;
        CFG_CARD_HEIGHT: card.height <= cfg_data;
        default: ;
      endcase
    end
  end

  nec_core #(
    .MAX_ENVELOPES(MAX_ENVELOPES),
    .SIZE_BITS    (SIZE_BITS)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .in_valid (env.valid),
    .in_ready (env.ready),
    .in_data  (env.data),
    .card     (card),
    .res_valid(core_valid),
    .res_ready(core_ready),
    .res_data (core_data)
  );

  // The core may hand over a beat whenever the output register is empty or
  // is being drained in this same cycle.
  assign core_ready = !out_valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (core_valid && core_ready) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (core_valid && core_ready) begin
      out_data <= core_data;
    end
  end

  assign res.valid = out_valid;
  assign res.data  = out_data;

endmodule

FILE: rtl/nec_checker.sv
module nec_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_ready,
  input nec_pkg::nec_res_t out_data
);
  import nec_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  a_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.entry_valid |->
      out_data.last_result && (out_data.chain_length == '0) &&
      (out_data.envelope_number == '0))
    else $error("empty chain beat malformed");

  a_member: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.entry_valid |->
      (out_data.chain_length != '0) && (out_data.envelope_number != '0))
    else $error("chain member beat has zero length or number");

  a_run_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_data.last_result |=> !out_valid)
    else $error("result beat followed the final beat of a run");

endmodule

bind nested_envelope_chain nec_checker u_nec_checker (
  .clk      (clk),
  .rst      (rst),
  .out_valid(res.valid),
  .out_ready(res.ready),
  .out_data (res.data)
);
